// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: op codes, widths, sequencer states.
// Used by rau_core.sv and rational_arithmetic_unit.sv.
package rau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned NumWidth     = 33;
  localparam int unsigned DenWidth     = 31;

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpEq  = 3'd4,
    OpGt  = 3'd5,
    OpLt  = 3'd6,
    OpNop = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StRedA,
    StRedB,
    StMul1,
    StMul2,
    StMul3,
    StComb,
    StRedR,
    StOut
  } state_e;

  // Sub-steps of one reduction, run on the shared divider.
  typedef enum logic [2:0] {
    RdGcd,
    RdDivN,
    RdDivD,
    RdDone
  } red_e;

endpackage

// ===== rtl/rau_core.sv =====
// Reduction engine: Euclid GCD and exact divides on one shared bit-serial divider.
// Depends on rau_pkg.
module rau_core #(
  parameter int unsigned W = 2 * rau_pkg::OperandWidth + 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] n_i,
  input  logic [W-1:0] d_i,
  output logic         done_o,
  output logic [W-1:0] n_o,
  output logic [W-1:0] d_o
);

  localparam int unsigned CW = $clog2(W + 1);

  rau_pkg::red_e step_q, step_d;
  logic          busy_q, busy_d;
  logic          dv_busy_q, dv_busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d, g_q, g_d, n_q, n_d, d_q, d_d;
  logic [W:0]    trial;
  logic [W-1:0]  rem_sh;

  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

  always_comb begin
    step_d    = step_q;
    busy_d    = busy_q;
    dv_busy_d = dv_busy_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    x_d       = x_q;
    y_d       = y_q;
    g_d       = g_q;
    n_d       = n_q;
    d_d       = d_q;
    done_o    = 1'b0;
    if (start_i) begin
      busy_d    = 1'b1;
      step_d    = rau_pkg::RdGcd;
      dv_busy_d = 1'b0;
      x_d       = n_i;
      y_d       = d_i;
      n_d       = n_i;
      d_d       = d_i;
    end else if (busy_q) begin
      if (dv_busy_q) begin
        // one restoring quotient bit per cycle
        if (trial[W]) begin
          rem_d = rem_sh;
          quo_d = {quo_q[W-2:0], 1'b0};
        end else begin
          rem_d = trial[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          dv_busy_d = 1'b0;
          case (step_q)
            rau_pkg::RdGcd: begin
              x_d = y_q;
              y_d = rem_d;
            end
            rau_pkg::RdDivN: begin
              n_d    = quo_d;
              step_d = rau_pkg::RdDivD;
            end
            rau_pkg::RdDivD: begin
              d_d    = quo_d;
              step_d = rau_pkg::RdDone;
            end
            default: ;
          endcase
        end
      end else begin
        case (step_q)
          rau_pkg::RdGcd: begin
            if (y_q == '0) begin
              g_d    = (x_q == '0) ? W'(1) : x_q;
              step_d = rau_pkg::RdDivN;
            end else begin
              dv_busy_d = 1'b1;
              quo_d     = x_q;
              rem_d     = '0;
              dvs_d     = y_q;
              cnt_d     = CW'(W);
            end
          end
          rau_pkg::RdDivN: begin
            dv_busy_d = 1'b1;
            quo_d     = n_q;
            rem_d     = '0;
            dvs_d     = g_q;
            cnt_d     = CW'(W);
          end
          rau_pkg::RdDivD: begin
            dv_busy_d = 1'b1;
            quo_d     = d_q;
            rem_d     = '0;
            dvs_d     = g_q;
            cnt_d     = CW'(W);
          end
          default: begin
            busy_d = 1'b0;
            done_o = 1'b1;
          end
        endcase
      end
    end
  end

  assign n_o = n_q;
  assign d_o = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      dv_busy_q <= 1'b0;
      step_q    <= rau_pkg::RdGcd;
      cnt_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      dv_busy_q <= dv_busy_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    x_q   <= x_d;
    y_q   <= y_d;
    g_q   <= g_d;
    n_q   <= n_d;
    d_q   <= d_d;
  end

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier, result register.
// Depends on rau_pkg and rau_core.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_ready_o op, a_num, a_den, b_num, b_den
//   out      output     out_valid_o/out_ready_i res_num, res_den, cmp_true, div_by_zero
//
// One transaction at a time through the sequencer. Each reduction runs Euclid on a bit-serial
// divider of 2*OPERAND_WIDTH+2 bits, one quotient bit per cycle; three reductions for arithmetic
// ops, two for compares. A zero input denominator skips the reductions: StRedA goes straight
// to StOut, which loads the output register.
// Reset clears the sequencer and the output valid. The output register frees the sequencer; the
// input stalls whenever the sequencer is busy, as when a result waits behind one not yet taken.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          op_i,
  input  logic signed [OPERAND_WIDTH-1:0]     a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]     a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]     b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]     b_den_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rau_pkg::NumWidth-1:0] res_num_o,
  output logic [rau_pkg::DenWidth-1:0]        res_den_o,
  output logic                                cmp_true_o,
  output logic                                div_by_zero_o
);

  localparam int unsigned OW = OPERAND_WIDTH;
  localparam int unsigned M  = 2 * OW + 2;   // magnitude width of products and sums
  localparam int unsigned PW = M + 1;        // signed product width

  rau_pkg::state_e st_q, st_d;
  rau_pkg::op_e    op_q;
  logic signed [OW:0]   an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] p1_q, p2_q, rn_q, rd_q;
  logic                 dz_q, cmp_q, neg_q;

  logic signed [OW:0]   mul_a, mul_b;
  logic signed [2*OW+1:0] mul_p;
  logic                 core_start, core_done;
  logic [M-1:0]         core_n, core_d, core_no, core_do;
  logic signed [PW-1:0] src_n, src_d, red_n, red_d, comb;
  logic                 load_in, out_fire, out_load;

  logic                                out_valid_q;
  logic signed [rau_pkg::NumWidth-1:0] res_num_q;
  logic [rau_pkg::DenWidth-1:0]        res_den_q;
  logic                                res_cmp_q, res_dz_q;

  assign load_in  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  // move a finished result into the output register when it is free or emptying
  assign out_load = (st_q == rau_pkg::StOut) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (st_q == rau_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  // shared multiplier
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (st_q)
      rau_pkg::StMul1: begin
        mul_a = an_q;
        mul_b = (op_q == rau_pkg::OpMul) ? bn_q : bd_q;
      end
      rau_pkg::StMul2: begin
        mul_a = (op_q == rau_pkg::OpDiv) ? bn_q : ad_q;
        mul_b = (op_q == rau_pkg::OpDiv) ? ad_q : bn_q;
      end
      rau_pkg::StMul3: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (st_q)
      rau_pkg::StRedA: begin
        src_n = PW'(an_q);
        src_d = PW'(ad_q);
      end
      rau_pkg::StRedB: begin
        src_n = PW'(bn_q);
        src_d = PW'(bd_q);
      end
      default: begin
        src_n = rn_q;
        src_d = rd_q;
      end
    endcase
    core_n = src_n[PW-1] ? M'(-src_n) : M'(src_n);
    core_d = src_d[PW-1] ? M'(-src_d) : M'(src_d);
    red_n  = neg_q ? -PW'(core_no) : PW'(core_no);
    red_d  = PW'(core_do);
  end

  assign comb = (op_q == rau_pkg::OpSub) ? (p1_q - p2_q) : (p1_q + p2_q);

  // next state
  logic started_q;
  always_comb begin
    st_d = st_q;
    case (st_q)
      rau_pkg::StIdle: if (load_in) st_d = rau_pkg::StRedA;
      rau_pkg::StRedA: begin
        if (dz_q) st_d = rau_pkg::StOut;
        else if (core_done) st_d = rau_pkg::StRedB;
      end
      rau_pkg::StRedB: if (core_done) st_d = rau_pkg::StMul1;
      rau_pkg::StMul1: begin
        if (op_q == rau_pkg::OpEq || op_q == rau_pkg::OpNop) st_d = rau_pkg::StOut;
        else st_d = rau_pkg::StMul2;
      end
      rau_pkg::StMul2: begin
        if (op_q == rau_pkg::OpGt || op_q == rau_pkg::OpLt) st_d = rau_pkg::StOut;
        else st_d = rau_pkg::StMul3;
      end
      rau_pkg::StMul3: st_d = rau_pkg::StComb;
      rau_pkg::StComb: st_d = (rd_q == '0) ? rau_pkg::StOut : rau_pkg::StRedR;
      rau_pkg::StRedR: if (core_done) st_d = rau_pkg::StOut;
      rau_pkg::StOut:  if (out_load) st_d = rau_pkg::StIdle;
      default: st_d = rau_pkg::StIdle;
    endcase
  end

  // start the reduction engine once on entry to each reduce state unless dz_q is set
  assign core_start = !started_q && !dz_q &&
                      (st_q == rau_pkg::StRedA || st_q == rau_pkg::StRedB ||
                       st_q == rau_pkg::StRedR);

  rau_core #(.W(M)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .n_i     (core_n),
    .d_i     (core_d),
    .done_o  (core_done),
    .n_o     (core_no),
    .d_o     (core_do)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= rau_pkg::StIdle;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      if (st_d != st_q) started_q <= 1'b0;
      else if (core_start) started_q <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_start) neg_q <= src_n[PW-1] ^ src_d[PW-1];
    case (st_q)
      rau_pkg::StIdle: if (load_in) begin
        op_q  <= rau_pkg::op_e'(op_i);
        an_q  <= (OW+1)'(a_num_i);
        ad_q  <= (OW+1)'(a_den_i);
        bn_q  <= (OW+1)'(b_num_i);
        bd_q  <= (OW+1)'(b_den_i);
        dz_q  <= (a_den_i == '0) || (b_den_i == '0);
        cmp_q <= 1'b0;
        rn_q  <= '0;
        rd_q  <= PW'(1);
      end
      rau_pkg::StRedA: if (core_done) begin
        an_q <= (OW+1)'(red_n);
        ad_q <= (OW+1)'(red_d);
      end
      rau_pkg::StRedB: if (core_done) begin
        bn_q <= (OW+1)'(red_n);
        bd_q <= (OW+1)'(red_d);
      end
      rau_pkg::StMul1: begin
        p1_q <= PW'(mul_p);
        if (op_q == rau_pkg::OpEq) cmp_q <= (an_q == bn_q) && (ad_q == bd_q);
      end
      rau_pkg::StMul2: begin
        p2_q <= PW'(mul_p);
        if (op_q == rau_pkg::OpGt) cmp_q <= p1_q > PW'(mul_p);
        if (op_q == rau_pkg::OpLt) cmp_q <= p1_q < PW'(mul_p);
      end
      rau_pkg::StMul3: begin
        rd_q <= (op_q == rau_pkg::OpDiv) ? p2_q : PW'(mul_p);
        rn_q <= (op_q == rau_pkg::OpMul || op_q == rau_pkg::OpDiv) ? p1_q : '0;
      end
      rau_pkg::StComb: begin
        if (op_q == rau_pkg::OpAdd || op_q == rau_pkg::OpSub) rn_q <= comb;
        if (rd_q == '0) dz_q <= 1'b1;
      end
      rau_pkg::StRedR: if (core_done) begin
        rn_q <= red_n;
        rd_q <= red_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_num_q <= dz_q ? '0 : rau_pkg::NumWidth'(rn_q);
      res_den_q <= dz_q ? '0 : rau_pkg::DenWidth'(rd_q);
      res_cmp_q <= !dz_q && cmp_q;
      res_dz_q  <= dz_q;
    end
  end

  assign res_num_o     = res_num_q;
  assign res_den_o     = res_den_q;
  assign cmp_true_o    = res_cmp_q;
  assign div_by_zero_o = res_dz_q;

endmodule
